// ===== sv/lbh_pkg.sv =====
// ----------------------------------------------------------------------------
// lbh_pkg: shared types and constants for the log-bucket latency histogram
// ----------------------------------------------------------------------------
package lbh_pkg;

  localparam int unsigned BucketCountDef = 256;
  localparam int unsigned CountWidthDef  = 32;
  localparam int unsigned ValW           = 63;
  localparam int unsigned TotalW         = 40;
  localparam int unsigned QW             = 17;
  localparam logic [ValW-1:0] ValMax     = {ValW{1'b1}};
  localparam logic [QW-1:0]   QOne       = QW'(65536);

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  // bound i of the log-scale rom, rebuilt from the fixed-point recurrence
  function automatic logic [ValW-1:0] bound_at(input int unsigned idx);
    logic [63:0] ip, fp, prev, ub, f21, i21, r;
    logic        sat;
    ip = 64'd1;
    fp = 64'd0;
    prev = 64'd0;
    ub = 64'd0;
    sat = 1'b0;
    for (int unsigned i = 0; i <= idx; i++) begin
      if (sat) begin
        ub = {1'b0, ValMax};
      end else begin
        ub = ip + ((fp >= 64'h8000_0000) ? 64'd1 : 64'd0);
        if (ub > {1'b0, ValMax}) ub = {1'b0, ValMax};
      end
      if (ub < 64'd1) ub = 64'd1;
      if (i > 0 && ub <= prev) ub = (prev >= {1'b0, ValMax}) ? {1'b0, ValMax} : prev + 64'd1;
      prev = ub;
      if (!sat) begin
        if (ip >= (64'd1 << 58)) begin
          sat = 1'b1;
        end else begin
          f21 = fp * 64'd21;
          i21 = ip * 64'd21 + (f21 >> 32);
          f21 = f21 & 64'hFFFF_FFFF;
          r   = i21 % 64'd20;
          ip  = i21 / 64'd20;
          fp  = ((r << 32) | f21) / 64'd20;
        end
      end
    end
    return ub[ValW-1:0];
  endfunction

endpackage

// ===== sv/lbh_cell.sv =====
// ----------------------------------------------------------------------------
// lbh_cell: one bucket of the histogram chain
// ----------------------------------------------------------------------------
module lbh_cell #(
  parameter int unsigned CountWidth = lbh_pkg::CountWidthDef,
  parameter logic [lbh_pkg::ValW-1:0] Bound = '0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      inc_i,
  input  logic                      shift_i,
  input  logic [CountWidth-1:0]     cnt_i,
  output logic [CountWidth-1:0]     cnt_o,
  output logic [lbh_pkg::ValW-1:0]  bound_o
);
  import lbh_pkg::*;

  logic [CountWidth-1:0] cnt_q, cnt_d;

  // during a walk the counts rotate through the chain toward cell 0
  always_comb begin
    cnt_d = cnt_q;
    if (shift_i) begin
      cnt_d = cnt_i;
    end else if (inc_i && cnt_q != {CountWidth{1'b1}}) begin
      cnt_d = cnt_q + CountWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o   = cnt_q;
  assign bound_o = Bound;
endmodule

// ===== sv/log_bucket_latency_histogram.sv =====
// ----------------------------------------------------------------------------
// log_bucket_latency_histogram: log-scale latency histogram with quantiles
// ----------------------------------------------------------------------------
// A record beat is compared against all bucket bounds at once (a registered
// compare row), then the matching cell of the bucket chain counts up. A record
// steps through ST_FIND, ST_INC and ST_DONE in that order. A query with q
// strictly between zero and one on a non-empty histogram rotates the bucket
// counts through the cell chain for a full lap, one bucket per cycle, summing
// at cell 0, before it reaches ST_DONE. A query with q of zero, or of one or
// more, or on an empty histogram, goes straight to ST_DONE. One beat is in
// flight at a time. The output register frees the input as soon as the result
// is parked. A result still waiting on m_axis_tready holds the next beat in
// ST_DONE until the waiting result is taken.
module log_bucket_latency_histogram #(
  parameter int unsigned BucketCount = lbh_pkg::BucketCountDef,
  parameter int unsigned CountWidth  = lbh_pkg::CountWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,  // sample_ns[63:0], quantile_q16[80:64]
  input  logic         s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [239:0] m_axis_tdata   // quantile_ns, bucket_index, sample_count,
                                      // min_seen_ns, max_seen_ns
);
  import lbh_pkg::*;

  localparam int unsigned IdxW = $clog2(BucketCount);
  localparam int unsigned AccW = CountWidth + IdxW + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FIND, ST_INC, ST_WALK, ST_DONE
  } state_e;

  state_e                state_q;
  logic [ValW-1:0]       samp_q;
  logic [TotalW-1:0]     total_q;
  logic [ValW-1:0]       min_q, max_q;
  logic [ValW-1:0]       qans_q;
  logic [IdxW-1:0]       bidx_q, walk_q;
  logic [BucketCount-1:0] ge_q;
  logic [AccW-1:0]       acc_q;
  logic [TotalW+QW-1:0]  target_q;
  logic                  out_v_q;
  logic [239:0]          out_q;

  logic [CountWidth-1:0] cnt  [BucketCount];
  logic [ValW-1:0]       bnd  [BucketCount];
  logic [BucketCount-1:0] inc;
  logic                  shift;

  assign shift = (state_q == ST_WALK);

  for (genvar g = 0; g < BucketCount; g++) begin : g_cell
    lbh_cell #(.CountWidth(CountWidth), .Bound(bound_at(g))) u_cell (
      .clk_i, .rst_ni,
      .inc_i  (inc[g]),
      .shift_i(shift),
      .cnt_i  (cnt[(g + 1) % BucketCount]),
      .cnt_o  (cnt[g]),
      .bound_o(bnd[g])
    );
  end

  // first set bit of the compare row, or the last bucket
  logic [IdxW-1:0] first_ge;
  always_comb begin
    first_ge = IdxW'(BucketCount - 1);
    for (int i = BucketCount - 1; i >= 0; i--) begin
      if (ge_q[i]) first_ge = IdxW'(i);
    end
  end

  always_comb begin
    inc = '0;
    if (state_q == ST_INC) inc[bidx_q] = 1'b1;
  end

  // bound seen with the count now at cell 0
  logic [ValW-1:0] walk_bnd;
  assign walk_bnd = bnd[walk_q];

  logic [AccW-1:0] acc_nx;
  assign acc_nx = acc_q + AccW'(cnt[0]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  logic [ValW-1:0] s_clamp;
  assign s_clamp = s_axis_tdata[63] ? '0 : s_axis_tdata[62:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      min_q   <= ValMax;
      max_q   <= '0;
      out_v_q <= 1'b0;
      walk_q  <= '0;
    end else begin
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            samp_q <= s_clamp;
            qans_q <= '0;
            bidx_q <= '0;
            if (cmd_e'(s_axis_tuser) == CMD_RECORD) begin
              for (int i = 0; i < BucketCount; i++) ge_q[i] <= (bnd[i] >= s_clamp);
              state_q <= ST_FIND;
            end else if (s_axis_tdata[80:64] == '0) begin
              qans_q  <= min_q;
              state_q <= ST_DONE;
            end else if (s_axis_tdata[80:64] >= QOne) begin
              qans_q  <= max_q;
              state_q <= ST_DONE;
            end else if (total_q == '0) begin
              state_q <= ST_DONE;
            end else begin
              target_q <= (TotalW+QW)'(total_q) * (TotalW+QW)'(s_axis_tdata[80:64]);
              acc_q    <= '0;
              walk_q   <= '0;
              state_q  <= ST_WALK;
            end
          end
        end
        ST_FIND: begin
          bidx_q  <= first_ge;
          state_q <= ST_INC;
        end
        ST_INC: begin
          if (total_q != {TotalW{1'b1}}) total_q <= total_q + TotalW'(1);
          if (samp_q < min_q) min_q <= samp_q;
          if (samp_q > max_q) max_q <= samp_q;
          state_q <= ST_DONE;
        end
        ST_WALK: begin
          // counts rotate a full lap, so state ends where it began
          acc_q  <= acc_nx;
          walk_q <= walk_q + IdxW'(1);
          if ((TotalW+QW)'(acc_nx) >= (target_q >> 16) && !ge_q[0]) begin
            ge_q[0] <= 1'b1;
            qans_q  <= walk_bnd;
          end
          if (walk_q == IdxW'(BucketCount - 1)) begin
            if (!((TotalW+QW)'(acc_nx) >= (target_q >> 16)) && !ge_q[0]) qans_q <= max_q;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_v_q) begin
            out_q   <= {3'b000, max_q, min_q, total_q, 8'(bidx_q), qans_q};
            out_v_q <= 1'b1;
            ge_q[0] <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/lbh_checker.sv =====
// ----------------------------------------------------------------------------
// lbh_checker: port-level checks for the latency histogram
// ----------------------------------------------------------------------------
module lbh_props (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [239:0] m_axis_tdata
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");
  // one beat in flight: input closes right after an accept
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accepted while busy");
  // a waiting result stays offered until taken
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  // min never above max once something recorded
  a_minmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[110:71] != '0 |->
      m_axis_tdata[173:111] <= m_axis_tdata[236:174]) else $error("min above max");
endmodule

bind log_bucket_latency_histogram lbh_props u_lbh_props (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// ===== tb/lbh_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbh_checker: result predictor and comparator for the latency histogram
// ----------------------------------------------------------------------------
// Watches both stream channels. Every accepted input beat updates a local copy
// of the histogram state and queues the expected result beat. Every accepted
// output beat is compared field by field against the oldest entry.
module lbh_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [239:0] m_axis_tdata,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);
  import lbh_pkg::*;

  localparam int unsigned NumBuckets = 256;
  localparam logic [31:0] BucketFull = '1;
  localparam logic [TotalW-1:0] TotalFull = '1;

  typedef struct packed {
    logic [ValW-1:0]   max_ns;
    logic [ValW-1:0]   min_ns;
    logic [TotalW-1:0] total;
    logic [7:0]        bucket;
    logic [ValW-1:0]   quant_ns;
  } hist_result_t;

  logic [ValW-1:0]   bounds [NumBuckets];
  logic [31:0]       hist_counts [NumBuckets];
  logic [TotalW-1:0] hist_total;
  logic [ValW-1:0]   hist_min, hist_max;
  hist_result_t      expected_results [$];
  int unsigned       fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();

  // rom built here from its own fixed-point recurrence
  initial begin
    logic [63:0] ip, fp, prev, ub, f21, i21, rem;
    ip = 64'd1;
    fp = 64'd0;
    prev = 64'd0;
    for (int i = 0; i < NumBuckets; i++) begin
      ub = ip + ((fp >= 64'h8000_0000) ? 64'd1 : 64'd0);
      if (i > 0 && ub <= prev) ub = prev + 64'd1;
      bounds[i] = ub[ValW-1:0];
      prev = ub;
      f21 = fp * 64'd21;
      i21 = ip * 64'd21 + (f21 >> 32);
      f21 = f21 & 64'hFFFF_FFFF;
      rem = i21 % 64'd20;
      ip  = i21 / 64'd20;
      fp  = ((rem << 32) | f21) / 64'd20;
    end
  end

  function automatic hist_result_t apply_beat(input logic is_query, input logic [63:0] smp,
                                              input logic [QW-1:0] q);
    hist_result_t res;
    logic [ValW-1:0] s;
    logic [63:0] target, run_sum;
    int b;
    bit hit;
    res = '0;
    if (is_query == CMD_RECORD) begin
      s = smp[63] ? '0 : smp[ValW-1:0];
      b = NumBuckets - 1;
      for (int i = NumBuckets - 1; i >= 0; i--) if (bounds[i] >= s) b = i;
      if (hist_counts[b] != BucketFull) hist_counts[b]++;
      if (hist_total != TotalFull) hist_total++;
      if (s < hist_min) hist_min = s;
      if (s > hist_max) hist_max = s;
      res.bucket = b[7:0];
    end else begin
      if (q == '0) res.quant_ns = hist_min;
      else if (q >= QOne) res.quant_ns = hist_max;
      else if (hist_total == '0) res.quant_ns = '0;
      else begin
        target = (64'(hist_total) * 64'(q)) >> 16;
        run_sum = '0;
        hit = 0;
        for (int i = 0; i < NumBuckets && !hit; i++) begin
          run_sum += 64'(hist_counts[i]);
          if (run_sum >= target) begin
            res.quant_ns = bounds[i];
            hit = 1;
          end
        end
        if (!hit) res.quant_ns = hist_max;
      end
    end
    res.total  = hist_total;
    res.min_ns = hist_min;
    res.max_ns = hist_max;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [ValW-1:0] exp_v,
                             input logic [ValW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hist_result_t exp_r, act_r;
    if (!rst_ni) begin
      for (int i = 0; i < NumBuckets; i++) hist_counts[i] = '0;
      hist_total = '0;
      hist_min = ValMax;
      hist_max = '0;
      fails = 0;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(apply_beat(s_axis_tuser, s_axis_tdata[63:0],
                                              s_axis_tdata[80:64]));
      if (m_axis_tvalid && m_axis_tready) begin
        act_r = m_axis_tdata[$bits(hist_result_t)-1:0];
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("quantile_ns", exp_r.quant_ns, act_r.quant_ns);
          check_field("bucket_index", ValW'(exp_r.bucket), ValW'(act_r.bucket));
          check_field("sample_count", ValW'(exp_r.total), ValW'(act_r.total));
          check_field("min_seen_ns", exp_r.min_ns, act_r.min_ns);
          check_field("max_seen_ns", exp_r.max_ns, act_r.max_ns);
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the log-bucket latency histogram
// ----------------------------------------------------------------------------
// Directed beats hit the query corners on an empty histogram, sample extremes
// and negative values, then random records and queries follow with bursty
// idling on both sides. Checking is done by lbh_checker.
module tb;
  import lbh_pkg::*;

  localparam int unsigned NumRandom = 950;
  localparam int unsigned CycleLimit = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [239:0] m_axis_tdata;
  int unsigned  fail_count, pending;
  int unsigned  cycles = 0;
  bit           calm = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  log_bucket_latency_histogram dut (.*);

  lbh_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver backpressure in bursts
  always @(posedge clk_i) begin
    int unsigned stall_left;
    if (!rst_ni) stall_left = 0;
    else if (calm) m_axis_tready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  // valid stays up between back-to-back beats and drops only for idling
  task automatic send_beat(input cmd_e cmd, input logic [63:0] smp, input logic [QW-1:0] q);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, q, smp};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [63:0] rand_sample();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return v;
      1: return v >> $urandom_range(1, 63);
      2: return 64'($urandom_range(0, 3));
      default: return 64'(v[31:0] >> $urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    logic [QW-1:0] q;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // empty histogram corners
    send_beat(CMD_QUERY, '0, '0);
    send_beat(CMD_QUERY, '0, 17'd32768);
    send_beat(CMD_QUERY, '0, QOne);
    send_beat(CMD_QUERY, '1, '1);
    // sample extremes, negatives and bounds
    send_beat(CMD_RECORD, 64'h8000_0000_0000_0000, '1);
    send_beat(CMD_RECORD, '1, '0);
    send_beat(CMD_RECORD, 64'd0, '0);
    send_beat(CMD_RECORD, 64'd1, '0);
    send_beat(CMD_RECORD, 64'd2, '0);
    send_beat(CMD_RECORD, 64'h7FFF_FFFF_FFFF_FFFF, '0);
    send_beat(CMD_RECORD, 64'h0000_000F_FFFF_FFFF, '0);
    send_beat(CMD_RECORD, 64'h5555_5555_5555_5555, '0);
    send_beat(CMD_RECORD, 64'd1000, '0);
    send_beat(CMD_QUERY, '0, '0);
    send_beat(CMD_QUERY, '0, 17'd1);
    send_beat(CMD_QUERY, '0, 17'd65535);
    send_beat(CMD_QUERY, '0, 17'd32768);
    send_beat(CMD_QUERY, '0, '1);
    for (int n = 0; n < NumRandom; n++) begin
      if (n > NumRandom - 80) calm = 1;
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 5))
          0: q = '0;
          1: q = QW'($urandom_range(65536, 131071));
          default: q = QW'($urandom_range(1, 65535));
        endcase
        send_beat(CMD_QUERY, {$urandom, $urandom}, q);
      end else begin
        send_beat(CMD_RECORD, rand_sample(), QW'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
